// ===== hw/rtl/htfd_pkg.sv =====
// htfd_pkg: item types, reply-frame constants and the crc-8 byte step
// shared by the frame decoder and its conversion stage; depends on nothing
`timescale 1ns / 1ps

package htfd_pkg;

  // input item: one byte of the reply and its start-of-frame flag
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_t;

  // result item: converted values and the check flag
  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;
    logic               crc_error;
  } out_t;

  // crc-8 settings
  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] CrcInit = 8'hFF;

  // conversion constants
  localparam logic [12:0] TScale  = 13'd4375;
  localparam logic [14:0] TOffset = 15'd4500;
  localparam logic [9:0]  HScale  = 10'd625;

  // byte positions inside a reply
  localparam logic [2:0] PosTempHi = 3'd0;
  localparam logic [2:0] PosTempLo = 3'd1;
  localparam logic [2:0] PosTempCrc = 3'd2;
  localparam logic [2:0] PosHumHi = 3'd3;
  localparam logic [2:0] PosHumLo = 3'd4;
  localparam logic [2:0] PosHumCrc = 3'd5;

  // one byte through the crc, msb first
  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/humidity_temp_frame_decoder.sv =====
// humidity_temp_frame_decoder: top level of the six-byte reply decoder
// depends on htfd_pkg and htfd_convert
`timescale 1ns / 1ps

// Usage
//   item channel: one reply byte per item (item_valid / item_stall). The
//   bytes are temperature high, low, crc, humidity high, low, crc. Setting
//   frame_start on a byte makes it the first byte of a new reply; without
//   it the position wraps after the sixth byte.
//   result channel: one item per reply (result_valid / result_stall), with
//   the temperature and humidity in hundredths, or zeros and crc_error set
//   when either word failed its crc-8 check.
//   Throughput: one byte per cycle unless a held result stalls input, set
//   by the single crc step and the two constant multiplies between the
//   input register and the result register. An accepted sixth byte sits
//   in the input register; the result register loads from it once no
//   held result blocks it.
//   Stall: a held result blocks only the sixth byte of the next reply; the
//   other bytes keep flowing. The input register and the result register
//   act as the two stages, so item_stall rises only when a result is held.
//   Reset: position 0, crc 0xFF, no item or result pending.

module humidity_temp_frame_decoder (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  htfd_pkg::in_t  item,
  output logic           result_valid,
  input  logic           result_stall,
  output htfd_pkg::out_t result
);

  // input register
  logic          item_reg_valid;
  htfd_pkg::in_t item_reg;

  // frame state
  logic [2:0]  byte_position;
  logic [7:0]  running_crc;
  logic [15:0] temperature_raw;
  logic        temperature_crc_good;
  logic [7:0]  humidity_high_byte;
  logic [7:0]  humidity_low_byte;

  logic [2:0]  byte_position_next;
  logic [7:0]  running_crc_next;
  logic [15:0] temperature_raw_next;
  logic        temperature_crc_good_next;
  logic [7:0]  humidity_high_byte_next;
  logic [7:0]  humidity_low_byte_next;

  logic [2:0]     pos;
  logic           produce;
  logic           out_free;
  logic           go;
  logic           good;
  htfd_pkg::out_t conv;

  // effective position of the registered byte
  always_comb begin
    if (item_reg.frame_start || byte_position > htfd_pkg::PosHumCrc) begin
      pos = htfd_pkg::PosTempHi;
    end else begin
      pos = byte_position;
    end
  end

  assign produce    = (pos == htfd_pkg::PosHumCrc);
  assign out_free   = ~result_valid | ~result_stall;
  assign go         = item_reg_valid & (~produce | out_free);
  assign item_stall = item_reg_valid & ~go;
  assign good       = temperature_crc_good & (running_crc == item_reg.data_byte);

  // per-byte state update
  always_comb begin
    running_crc_next          = running_crc;
    temperature_raw_next      = temperature_raw;
    temperature_crc_good_next = temperature_crc_good;
    humidity_high_byte_next   = humidity_high_byte;
    humidity_low_byte_next    = humidity_low_byte;
    byte_position_next        = pos + 3'd1;
    case (pos)
      htfd_pkg::PosTempHi: begin
        temperature_raw_next = {item_reg.data_byte, 8'h00};
        running_crc_next     = htfd_pkg::crc_byte(htfd_pkg::CrcInit, item_reg.data_byte);
      end
      htfd_pkg::PosTempLo: begin
        temperature_raw_next = {temperature_raw[15:8], item_reg.data_byte};
        running_crc_next     = htfd_pkg::crc_byte(running_crc, item_reg.data_byte);
      end
      htfd_pkg::PosTempCrc: begin
        temperature_crc_good_next = (running_crc == item_reg.data_byte);
        running_crc_next          = htfd_pkg::CrcInit;
      end
      htfd_pkg::PosHumHi: begin
        humidity_high_byte_next = item_reg.data_byte;
        running_crc_next        = htfd_pkg::crc_byte(htfd_pkg::CrcInit, item_reg.data_byte);
      end
      htfd_pkg::PosHumLo: begin
        humidity_low_byte_next = item_reg.data_byte;
        running_crc_next       = htfd_pkg::crc_byte(running_crc, item_reg.data_byte);
      end
      default: begin
        running_crc_next   = htfd_pkg::CrcInit;
        byte_position_next = htfd_pkg::PosTempHi;
      end
    endcase
  end

  htfd_convert u_convert (
    .temp_raw (temperature_raw),
    .hum_raw  ({humidity_high_byte, humidity_low_byte}),
    .good     (good),
    .result   (conv)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_reg_valid <= 1'b0;
    end else if (!item_stall) begin
      item_reg_valid <= item_valid;
    end
    if (!item_stall && item_valid) begin
      item_reg <= item;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position        <= htfd_pkg::PosTempHi;
      running_crc          <= htfd_pkg::CrcInit;
      temperature_raw      <= 16'd0;
      temperature_crc_good <= 1'b0;
      humidity_high_byte   <= 8'd0;
      humidity_low_byte    <= 8'd0;
    end else if (go) begin
      byte_position        <= byte_position_next;
      running_crc          <= running_crc_next;
      temperature_raw      <= temperature_raw_next;
      temperature_crc_good <= temperature_crc_good_next;
      humidity_high_byte   <= humidity_high_byte_next;
      humidity_low_byte    <= humidity_low_byte_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (go && produce) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (go && produce) begin
      result <= conv;
    end
  end

  // checks
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= htfd_pkg::PosHumCrc)
    else $error("byte position out of range");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.crc_error |->
      result.temperature_centi == 15'sd0 && result.humidity_centi == 14'd0)
    else $error("failed reply carries nonzero values");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.crc_error |-> result.humidity_centi <= 14'd10000)
    else $error("humidity out of range");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    go && produce |=> result_valid)
    else $error("sixth byte gave no result");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> item_reg_valid && produce && result_valid && result_stall)
    else $error("input stalled without a held result");

endmodule

// ===== hw/rtl/htfd_convert.sv =====
// htfd_convert: scales the raw temperature and humidity words to hundredths
// and forces zeros on a failed check; depends on htfd_pkg
`timescale 1ns / 1ps

module htfd_convert (
  input  logic [15:0]       temp_raw,
  input  logic [15:0]       hum_raw,
  input  logic              good,
  output htfd_pkg::out_t    result
);

  logic [28:0] t_prod;
  logic [14:0] t_scaled;
  logic [14:0] t_centi;
  logic [25:0] h_prod;

  // constant multiplies, keep the integer part
  assign t_prod   = 29'(htfd_pkg::TScale) * 29'(temp_raw);
  assign t_scaled = t_prod[28:14];
  assign t_centi  = t_scaled - htfd_pkg::TOffset;
  assign h_prod   = 26'(htfd_pkg::HScale) * 26'(hum_raw);

  // zero both values when either word failed
  always_comb begin
    result.temperature_centi = good ? $signed(t_centi) : 15'sd0;
    result.humidity_centi    = good ? h_prod[25:12] : 14'd0;
    result.crc_error         = ~good;
  end

endmodule
